[src/hsd_pkg.sv]
`timescale 1ns / 1ps
// Shared register codes and reset values for the line fit detector.
package hsd_pkg;

  localparam int DATA_W = 16;

  localparam logic [1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_MIN_POINTS = 2'd1;
  localparam logic [1:0] REG_CMD_LOW    = 2'd2;
  localparam logic [1:0] REG_CMD_HIGH   = 2'd3;

  localparam logic [15:0] THRESHOLD_RST  = 16'd20;
  localparam logic [7:0]  MIN_POINTS_RST = 8'd10;
  localparam logic [15:0] CMD_LOW_RST    = 16'd0;
  localparam logic [15:0] CMD_HIGH_RST   = 16'hFFFF;

  localparam logic [20:0] PRED_LIMIT = 21'h100000;

  typedef struct packed {
    logic start;
    logic done;
  } seq_ctl_t;

endpackage

[src/hsd_mul.sv]
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module hsd_mul
  import hsd_pkg::*;
#(
  parameter int A_W = 48,
  parameter int B_W = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output seq_ctl_t             ctl,
  output logic [A_W+B_W-1:0]   prod
);

  localparam int CW = $clog2(B_W + 1);

  logic [A_W-1:0]     a_hold;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               done;
  logic [A_W:0]       hi;
  logic [A_W+B_W-1:0] prod_next;

  assign hi = {1'b0, prod[A_W+B_W-1:B_W]} + (prod[0] ? {1'b0, a_hold} : '0);
  assign prod_next = {hi, prod[B_W-1:1]};
  assign ctl.start = start;
  assign ctl.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_hold <= a;
        prod <= {{A_W{1'b0}}, b};
        cnt <= CW'(B_W);
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod_next;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/hsd_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, rounded half away from zero.
module hsd_div
  import hsd_pkg::*;
#(
  parameter int N_W = 73,
  parameter int D_W = 56
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output seq_ctl_t       ctl,
  output logic [N_W-1:0] quot
);

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] work;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] den_h;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [D_W:0]   sh;
  logic           ge;
  logic           rnd;

  assign sh = {rem, work[N_W-1]};
  assign ge = sh >= {1'b0, den_h};
  assign rnd = {rem, 1'b0} >= {1'b0, den_h};
  assign quot = work + N_W'(rnd);
  assign ctl.start = start;
  assign ctl.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work <= num;
        den_h <= den;
        rem <= '0;
        cnt <= CW'(N_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? D_W'(sh - {1'b0, den_h}) : sh[D_W-1:0];
        work <= {work[N_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/hard_stop_line_fit_detector.sv]
`timescale 1ns / 1ps
// Top level: least-squares line fit hard stop detector for an actuator sweep.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid/in_ready   | start_sweep, commanded_pos, reading
//  out      | out_valid/out_ready | predicted_reading, residual, stop_found,
//           |                     | out_of_bounds, stop_command, stop_reading
//  config   | APB psel/penable    | paddr, pwdata, prdata, pready
//
// One item at a time. A fitted point makes ten passes through the serial multiplier
// and one through the serial divider. With a full store the first two passes are
// skipped. Out-of-range and ignored steps go from the check straight to the output.
// Synchronous reset clears counts, sums, history and the done flag.
// A waiting result does not block acceptance; a finished result holds until
// the output register frees.
module hard_stop_line_fit_detector
  import hsd_pkg::*;
#(
  parameter int MAX_POINTS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        start_sweep,
  input  logic [15:0] commanded_pos,
  input  logic [15:0] reading,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] predicted_reading,
  output logic [15:0] residual,
  output logic        stop_found,
  output logic        out_of_bounds,
  output logic [15:0] stop_command,
  output logic [15:0] stop_reading,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = 16 + CNT_W;
  localparam int SXX_W = 32 + CNT_W;
  localparam int MA_W  = 32 + 2 * CNT_W;
  localparam int MB_W  = 16 + CNT_W;
  localparam int PR_W  = MA_W + MB_W;
  localparam int NUM_W = PR_W + 1;
  localparam int DV_W  = MA_W + CNT_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_FIT   = 3'd3;
  localparam logic [2:0] S_DWAIT = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [3:0] OP_XY   = 4'd0;
  localparam logic [3:0] OP_XX   = 4'd1;
  localparam logic [3:0] OP_NXX  = 4'd2;
  localparam logic [3:0] OP_SXSX = 4'd3;
  localparam logic [3:0] OP_NXY  = 4'd4;
  localparam logic [3:0] OP_SXSY = 4'd5;
  localparam logic [3:0] OP_NX   = 4'd6;
  localparam logic [3:0] OP_AB   = 4'd7;
  localparam logic [3:0] OP_SYD  = 4'd8;
  localparam logic [3:0] OP_ND   = 4'd9;

  logic [2:0] state;
  logic [3:0] mop;

  logic [15:0] threshold;
  logic [7:0]  min_points;
  logic [15:0] cmd_low;
  logic [15:0] cmd_high;

  logic [15:0]      x;
  logic [15:0]      y;
  logic [CNT_W-1:0] cnt;
  logic [SX_W-1:0]  sx;
  logic [SX_W-1:0]  sy;
  logic [SXX_W-1:0] sxy;
  logic [SXX_W-1:0] sxx;
  logic [15:0]      rc [3];
  logic [15:0]      rr [3];
  logic [2:0]       rf;
  logic             sweep_done;

  logic [MA_W-1:0]  t1;
  logic [MA_W-1:0]  dreg;
  logic [MA_W-1:0]  amag;
  logic             aneg;
  logic [MB_W-1:0]  bmag;
  logic             bneg;
  logic [PR_W-1:0]  term1;
  logic [NUM_W-1:0] num;
  logic             neg;
  logic             degen;
  logic [20:0]      q;

  logic        res_stop;
  logic        res_oob;
  logic [15:0] res_pred;
  logic [15:0] res_resid;
  logic [15:0] res_cmd;
  logic [15:0] res_read;

  logic             mul_start;
  logic             mul_start_next;
  logic [MA_W-1:0]  op_a;
  logic [MB_W-1:0]  op_b;
  seq_ctl_t         mul_ctl;
  logic [PR_W-1:0]  prod;
  logic [MA_W-1:0]  prod_a;

  logic             div_start;
  logic             div_start_next;
  seq_ctl_t         div_ctl;
  logic [NUM_W-1:0] quot;

  logic signed [22:0] p_s;
  logic signed [22:0] diff;
  logic [22:0]        absd;
  logic [15:0]        fit_resid;
  logic [15:0]        fit_pred;
  logic               exceed;
  logic               stop_hit;
  logic               cmd_oob;
  logic               oob_hit;

  assign pready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign prod_a = prod[MA_W-1:0];
  assign cmd_oob = (x < cmd_low) || (x > cmd_high);
  assign oob_hit = !sweep_done && cmd_oob;

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:  prdata = {16'd0, threshold};
      REG_MIN_POINTS: prdata = {24'd0, min_points};
      REG_CMD_LOW:    prdata = {16'd0, cmd_low};
      REG_CMD_HIGH:   prdata = {16'd0, cmd_high};
      default:        prdata = 32'd0;
    endcase
  end

  always_comb begin
    case (mop)
      OP_XY: begin
        op_a = MA_W'(x);
        op_b = MB_W'(y);
      end
      OP_XX: begin
        op_a = MA_W'(x);
        op_b = MB_W'(x);
      end
      OP_NXX: begin
        op_a = MA_W'(sxx);
        op_b = MB_W'(cnt);
      end
      OP_SXSX: begin
        op_a = MA_W'(sx);
        op_b = MB_W'(sx);
      end
      OP_NXY: begin
        op_a = MA_W'(sxy);
        op_b = MB_W'(cnt);
      end
      OP_SXSY: begin
        op_a = MA_W'(sx);
        op_b = MB_W'(sy);
      end
      OP_NX: begin
        op_a = MA_W'(x);
        op_b = MB_W'(cnt);
      end
      OP_AB: begin
        op_a = amag;
        op_b = bmag;
      end
      OP_SYD: begin
        op_a = dreg;
        op_b = MB_W'(sy);
      end
      OP_ND: begin
        op_a = dreg;
        op_b = MB_W'(cnt);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_comb begin
    mul_start_next = 1'b0;
    div_start_next = 1'b0;
    case (state)
      S_CHECK: mul_start_next = oob_hit ? 1'b0
                                        : (!sweep_done && (cnt < CNT_W'(MAX_POINTS)));
      S_FIT: mul_start_next = (cnt >= CNT_W'(2));
      S_MWAIT: begin
        if (mul_ctl.done) begin
          case (mop)
            OP_XY, OP_NXX, OP_NXY, OP_SXSY, OP_NX, OP_AB, OP_SYD: mul_start_next = 1'b1;
            OP_SXSX: mul_start_next = (t1 > prod_a);
            OP_ND:   div_start_next = 1'b1;
            default: mul_start_next = 1'b0;
          endcase
        end
      end
      default: mul_start_next = 1'b0;
    endcase
  end

  hsd_mul #(
    .A_W(MA_W),
    .B_W(MB_W)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (op_a),
    .b    (op_b),
    .ctl  (mul_ctl),
    .prod (prod)
  );

  hsd_div #(
    .N_W(NUM_W),
    .D_W(DV_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (num),
    .den  (prod[DV_W-1:0]),
    .ctl  (div_ctl),
    .quot (quot)
  );

  always_comb begin
    p_s = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    diff = $signed({7'd0, y}) - p_s;
    absd = diff[22] ? 23'(-diff) : 23'(diff);
    if (degen) begin
      fit_resid = 16'd0;
      fit_pred = y;
    end else begin
      fit_resid = (absd > 23'd65535) ? 16'hFFFF : absd[15:0];
      if (p_s[22]) begin
        fit_pred = 16'd0;
      end else if (p_s > 23'sd65535) begin
        fit_pred = 16'hFFFF;
      end else begin
        fit_pred = p_s[15:0];
      end
    end
    exceed = fit_resid > threshold;
    stop_hit = (16'(cnt) >= 16'(min_points)) && rf[1] && rf[2] && exceed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      min_points <= MIN_POINTS_RST;
      cmd_low <= CMD_LOW_RST;
      cmd_high <= CMD_HIGH_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_THRESHOLD:  threshold <= pwdata[15:0];
        REG_MIN_POINTS: min_points <= pwdata[7:0];
        REG_CMD_LOW:    cmd_low <= pwdata[15:0];
        REG_CMD_HIGH:   cmd_high <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mop <= OP_XY;
      mul_start <= 1'b0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
      cnt <= '0;
      sx <= '0;
      sy <= '0;
      sxy <= '0;
      sxx <= '0;
      rf <= '0;
      rc[0] <= '0;
      rc[1] <= '0;
      rc[2] <= '0;
      rr[0] <= '0;
      rr[1] <= '0;
      rr[2] <= '0;
      sweep_done <= 1'b0;
    end else begin
      mul_start <= mul_start_next;
      div_start <= div_start_next;
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x <= commanded_pos;
            y <= reading;
            if (start_sweep) begin
              cnt <= '0;
              sx <= '0;
              sy <= '0;
              sxy <= '0;
              sxx <= '0;
              rf <= '0;
              rc[0] <= '0;
              rc[1] <= '0;
              rc[2] <= '0;
              rr[0] <= '0;
              rr[1] <= '0;
              rr[2] <= '0;
              sweep_done <= 1'b0;
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_stop <= 1'b0;
          res_oob <= oob_hit;
          res_pred <= '0;
          res_resid <= '0;
          res_cmd <= (oob_hit && (cnt != '0)) ? rc[2] : '0;
          res_read <= (oob_hit && (cnt != '0)) ? rr[2] : '0;
          if (sweep_done) begin
            state <= S_OUT;
          end else if (cmd_oob) begin
            sweep_done <= 1'b1;
            state <= S_OUT;
          end else if (cnt < CNT_W'(MAX_POINTS)) begin
            mop <= OP_XY;
            state <= S_MWAIT;
          end else begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (cnt < CNT_W'(2)) begin
            degen <= 1'b1;
            state <= S_RES;
          end else begin
            mop <= OP_NXX;
            state <= S_MWAIT;
          end
        end
        S_MWAIT: begin
          if (mul_ctl.done) begin
            mop <= mop + 1'b1;
            case (mop)
              OP_XY: t1 <= prod_a;
              OP_XX: begin
                cnt <= cnt + 1'b1;
                sx <= sx + SX_W'(x);
                sy <= sy + SX_W'(y);
                sxy <= sxy + SXX_W'(t1);
                sxx <= sxx + SXX_W'(prod_a);
                state <= S_FIT;
              end
              OP_NXX: t1 <= prod_a;
              OP_SXSX: begin
                if (t1 <= prod_a) begin
                  degen <= 1'b1;
                  state <= S_RES;
                end else begin
                  dreg <= t1 - prod_a;
                end
              end
              OP_NXY: t1 <= prod_a;
              OP_SXSY: begin
                aneg <= t1 < prod_a;
                amag <= (t1 < prod_a) ? prod_a - t1 : t1 - prod_a;
              end
              OP_NX: begin
                bneg <= prod[MB_W-1:0] < sx;
                bmag <= (prod[MB_W-1:0] < sx) ? sx - prod[MB_W-1:0]
                                             : prod[MB_W-1:0] - sx;
              end
              OP_AB: term1 <= prod;
              OP_SYD: begin
                if (aneg != bneg) begin
                  if (prod < term1) begin
                    num <= NUM_W'(term1 - prod);
                    neg <= 1'b1;
                  end else begin
                    num <= NUM_W'(prod - term1);
                    neg <= 1'b0;
                  end
                end else begin
                  num <= NUM_W'(term1) + NUM_W'(prod);
                  neg <= 1'b0;
                end
              end
              OP_ND: begin
                state <= S_DWAIT;
              end
              default: ;
            endcase
          end
        end
        S_DWAIT: begin
          if (div_ctl.done) begin
            q <= (quot > NUM_W'(PRED_LIMIT)) ? PRED_LIMIT : quot[20:0];
            degen <= 1'b0;
            state <= S_RES;
          end
        end
        S_RES: begin
          res_pred <= fit_pred;
          res_resid <= fit_resid;
          rc[0] <= rc[1];
          rc[1] <= rc[2];
          rc[2] <= x;
          rr[0] <= rr[1];
          rr[1] <= rr[2];
          rr[2] <= y;
          rf <= {exceed, rf[2:1]};
          if (stop_hit) begin
            res_stop <= 1'b1;
            res_cmd <= rc[1];
            res_read <= rr[1];
            sweep_done <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            predicted_reading <= res_pred;
            residual <= res_resid;
            stop_found <= res_stop;
            out_of_bounds <= res_oob;
            stop_command <= res_cmd;
            stop_reading <= res_read;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/hsd_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the line fit detector, bound to the top level.
module hsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] predicted_reading,
  input logic [15:0] residual,
  input logic        stop_found,
  input logic        out_of_bounds,
  input logic [15:0] stop_command,
  input logic [15:0] stop_reading,
  input logic        pready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(residual) && $stable(stop_found))
    else $error("result dropped or changed while stalled");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(stop_found && out_of_bounds))
    else $error("stop and out-of-range flagged together");

  a_oob: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_bounds |-> predicted_reading == 16'd0 && residual == 16'd0)
    else $error("out-of-range transfer carries a prediction");

  a_nostop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stop_found && !out_of_bounds |->
      stop_command == 16'd0 && stop_reading == 16'd0)
    else $error("stop point reported without a stop");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind hard_stop_line_fit_detector hsd_checker u_hsd_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .predicted_reading(predicted_reading),
  .residual         (residual),
  .stop_found       (stop_found),
  .out_of_bounds    (out_of_bounds),
  .stop_command     (stop_command),
  .stop_reading     (stop_reading),
  .pready           (pready)
);
